[sv/scvs_pkg.sv]
// Shared types, constants and request codes for the sound clip table unit.
package scvs_pkg;

    localparam int CLIP_SLOTS  = 32;
    localparam int VOICE_COUNT = 24;
    localparam int IDX_W       = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;

    localparam int START_W = 19;
    localparam int RATE_W  = 16;
    localparam int ENTRY_W = START_W + RATE_W + 1;

    localparam logic [31:0] VAG_MAGIC    = 32'h7047_4156;
    localparam logic [19:0] VAG_HDR      = 20'd48;
    localparam logic [13:0] FULL_LEVEL   = 14'h3fff;
    localparam logic [15:0] NOLOOP_UNITS = 16'd512;
    localparam logic [19:0] BASE_RESET   = 20'd4112;
    localparam logic [19:0] LIMIT_RESET  = 20'd524288;
    localparam logic [8:0]  PAN_CENTER   = 9'sd64;
    localparam logic [6:0]  PAN_MAX      = 7'd127;

    // Reciprocals for exact floor division: x/127 for 21-bit x, and
    // rate*1024/11025 (same as rate*4096/44100) for 16-bit rate.
    localparam logic [21:0] PAN_RECIP   = 22'(((64'd1 << 28) + 64'd126) / 64'd127);
    localparam int          PAN_SHIFT   = 28;
    localparam logic [26:0] PITCH_RECIP = 27'(((64'd1 << 40) + 64'd11024) / 64'd11025);
    localparam int          PITCH_SHIFT = 30;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_PLAY   = 2'd1,
        REQ_VOLUME = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_INDEX  = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_NO_MEMORY  = 3'd3,
        ST_NOT_LOADED = 3'd4,
        ST_NO_VOICE   = 3'd5,
        ST_BAD_VOICE  = 3'd6
    } t_status;

    localparam logic CFG_RAM_BASE  = 1'b0;
    localparam logic CFG_RAM_LIMIT = 1'b1;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic mul;
        logic div;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[sv/scvs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/scvs_ctrl.sv]
// Request sequencer: steps one word through fetch, multiply, divide and commit.
module scvs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scvs_pkg::t_sts i_sts,
    output scvs_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_FETCH;
            S_FETCH: n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV:   n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cmd.accept  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.fetch   = (r_state == S_FETCH);
    assign o_cmd.mul     = (r_state == S_MUL);
    assign o_cmd.div     = (r_state == S_DIV);
    assign o_cmd.commit  = (r_state == S_DONE) && i_sts.out_free;

endmodule

[sv/scvs_datapath.sv]
// Clip table, allocator, pitch and volume arithmetic and the output register.
module scvs_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scvs_pkg::t_cmd i_cmd,
    output scvs_pkg::t_sts o_sts,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [19:0]    i_cfg_data,
    input  logic [1:0]     i_req_type,
    input  logic [7:0]     i_clip_index,
    input  logic [19:0]    i_size_bytes,
    input  logic [31:0]    i_header_magic,
    input  logic [15:0]    i_sample_rate,
    input  logic           i_loop_flag,
    input  logic signed [8:0] i_volume,
    input  logic signed [8:0] i_pan,
    input  logic [4:0]     i_channel,
    input  logic           i_voice_free,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_status,
    output logic [4:0]     o_voice,
    output logic [15:0]    o_start_units,
    output logic [15:0]    o_repeat_units,
    output logic [15:0]    o_pitch,
    output logic [13:0]    o_left_level,
    output logic [13:0]    o_right_level,
    output logic [6:0]     o_clips_loaded
);

    // Configuration and persistent state.
    logic [19:0]                     r_ram_base;
    logic [19:0]                     r_ram_limit;
    logic [19:0]                     r_next_free;
    logic [scvs_pkg::CLIP_SLOTS-1:0] r_present;
    logic [6:0]                      r_count;

    // Captured request word.
    logic [1:0]        r_req;
    logic [7:0]        r_idx;
    logic [19:0]       r_size;
    logic [31:0]       r_magic;
    logic [15:0]       r_rate;
    logic              r_loop;
    logic signed [8:0] r_vol;
    logic signed [8:0] r_pan;
    logic [4:0]        r_chan;
    logic              r_vfree;

    // Fetch stage results.
    logic [2:0]  r_status;
    logic [20:0] r_addr;
    logic [21:0] r_end;
    logic [13:0] r_lv;
    logic        r_center;
    logic [6:0]  r_p;
    logic [42:0] r_pitch_prod;
    logic [15:0] r_start_units;
    logic        r_loops;

    // Multiply and divide stage results.
    logic [20:0] r_prod_l;
    logic [20:0] r_prod_r;
    logic [13:0] r_lvl_l;
    logic [13:0] r_lvl_r;

    // Output register.
    logic        r_out_valid;
    logic [2:0]  r_o_status;
    logic [4:0]  r_o_voice;
    logic [15:0] r_o_start;
    logic [15:0] r_o_repeat;
    logic [15:0] r_o_pitch;
    logic [13:0] r_o_left;
    logic [13:0] r_o_right;
    logic [6:0]  r_o_count;

    logic [scvs_pkg::ENTRY_W-1:0] w_rdata;
    logic [scvs_pkg::ENTRY_W-1:0] w_wdata;
    logic                         w_we;
    logic [scvs_pkg::IDX_W-1:0]   w_slot;
    logic                         w_idx_bad;
    logic                         w_chan_bad;
    logic [19:0]                  w_size_eff;
    logic [20:0]                  w_addr;
    logic [20:0]                  w_asz;
    logic [21:0]                  w_end;
    logic [20:0]                  w_lv_full;
    logic [13:0]                  w_lv;
    logic [6:0]                   w_p;
    logic [2:0]                   w_status;
    logic [42:0]                  w_div_l;
    logic [42:0]                  w_div_r;
    logic                         w_ok;
    logic                         w_load_ok;
    logic                         w_has_voice;
    logic                         w_play_ok;
    logic [6:0]                   w_new_count;

    assign w_slot     = r_idx[scvs_pkg::IDX_W-1:0];
    assign w_idx_bad  = (r_idx >= 8'(scvs_pkg::CLIP_SLOTS));
    assign w_chan_bad = ({1'b0, r_chan} >= 6'(scvs_pkg::VOICE_COUNT));

    assign w_wdata = {r_addr[scvs_pkg::START_W-1:0], r_rate, r_loop};

    scvs_ram #(
        .WIDTH(scvs_pkg::ENTRY_W),
        .DEPTH(scvs_pkg::CLIP_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_slot),
        .i_wdata(w_wdata),
        .i_re   (i_cmd.accept),
        .i_raddr(i_clip_index[scvs_pkg::IDX_W-1:0]),
        .o_rdata(w_rdata)
    );

    // Allocation arithmetic.
    always_comb begin
        if (r_size >= scvs_pkg::VAG_HDR && r_magic == scvs_pkg::VAG_MAGIC) begin
            w_size_eff = r_size - scvs_pkg::VAG_HDR;
        end else begin
            w_size_eff = r_size;
        end
        w_addr = ({1'b0, r_next_free} + 21'd15) & ~21'd15;
        w_asz  = ({1'b0, w_size_eff} + 21'd15) & ~21'd15;
        w_end  = {1'b0, w_addr} + {1'b0, w_asz};
    end

    // Volume level and pan position.
    always_comb begin
        w_lv_full = {r_vol[6:0], 14'd0} - {14'd0, r_vol[6:0]};
        if (r_vol <= 9'sd0) begin
            w_lv = 14'd0;
        end else if (r_vol >= 9'sd128) begin
            w_lv = scvs_pkg::FULL_LEVEL;
        end else begin
            w_lv = w_lv_full[20:7];
        end
        if (r_pan < 9'sd0) begin
            w_p = 7'd0;
        end else if (r_pan > 9'sd127) begin
            w_p = scvs_pkg::PAN_MAX;
        end else begin
            w_p = r_pan[6:0];
        end
    end

    always_comb begin
        w_status = scvs_pkg::ST_OK;
        case (scvs_pkg::t_req'(r_req))
            scvs_pkg::REQ_LOAD: begin
                if (w_idx_bad) begin
                    w_status = scvs_pkg::ST_BAD_INDEX;
                end else if (r_size == 20'd0) begin
                    w_status = scvs_pkg::ST_ZERO_SIZE;
                end else if (w_end > {2'b00, r_ram_limit}) begin
                    w_status = scvs_pkg::ST_NO_MEMORY;
                end
            end
            scvs_pkg::REQ_PLAY: begin
                if (w_idx_bad) begin
                    w_status = scvs_pkg::ST_BAD_INDEX;
                end else if (!r_present[w_slot]) begin
                    w_status = scvs_pkg::ST_NOT_LOADED;
                end else if (!r_vfree) begin
                    w_status = scvs_pkg::ST_NO_VOICE;
                end else if (w_chan_bad) begin
                    w_status = scvs_pkg::ST_BAD_VOICE;
                end
            end
            scvs_pkg::REQ_VOLUME: begin
                if (w_chan_bad) begin
                    w_status = scvs_pkg::ST_BAD_VOICE;
                end
            end
            default: w_status = scvs_pkg::ST_OK;
        endcase
    end

    assign w_div_l = {22'd0, r_prod_l} * {21'd0, scvs_pkg::PAN_RECIP};
    assign w_div_r = {22'd0, r_prod_r} * {21'd0, scvs_pkg::PAN_RECIP};

    assign w_ok        = (r_status == scvs_pkg::ST_OK);
    assign w_load_ok   = w_ok && (r_req == scvs_pkg::REQ_LOAD);
    assign w_play_ok   = w_ok && (r_req == scvs_pkg::REQ_PLAY);
    assign w_has_voice = w_ok && (r_req == scvs_pkg::REQ_PLAY || r_req == scvs_pkg::REQ_VOLUME);
    assign w_we        = i_cmd.commit && w_load_ok;

    always_comb begin
        if (r_req == scvs_pkg::REQ_CLEAR) begin
            w_new_count = 7'd0;
        end else if (w_load_ok && !r_present[w_slot]) begin
            w_new_count = r_count + 7'd1;
        end else begin
            w_new_count = r_count;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_base  <= scvs_pkg::BASE_RESET;
            r_ram_limit <= scvs_pkg::LIMIT_RESET;
            r_next_free <= scvs_pkg::BASE_RESET;
            r_present   <= '0;
            r_count     <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    scvs_pkg::CFG_RAM_BASE:  r_ram_base  <= i_cfg_data;
                    scvs_pkg::CFG_RAM_LIMIT: r_ram_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_count     <= w_new_count;
                r_out_valid <= 1'b1;
                if (r_req == scvs_pkg::REQ_CLEAR) begin
                    r_present   <= '0;
                    r_next_free <= r_ram_base;
                end else if (w_load_ok) begin
                    r_present[w_slot] <= 1'b1;
                    r_next_free       <= r_end[19:0];
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req_type;
            r_idx   <= i_clip_index;
            r_size  <= i_size_bytes;
            r_magic <= i_header_magic;
            r_rate  <= i_sample_rate;
            r_loop  <= i_loop_flag;
            r_vol   <= i_volume;
            r_pan   <= i_pan;
            r_chan  <= i_channel;
            r_vfree <= i_voice_free;
        end
        if (i_cmd.fetch) begin
            r_status      <= w_status;
            r_addr        <= w_addr;
            r_end         <= w_end;
            r_lv          <= w_lv;
            r_center      <= (r_pan == scvs_pkg::PAN_CENTER);
            r_p           <= w_p;
            r_pitch_prod  <= {27'd0, w_rdata[scvs_pkg::RATE_W:1]}
                             * {16'd0, scvs_pkg::PITCH_RECIP};
            r_start_units <= w_rdata[scvs_pkg::ENTRY_W-1:scvs_pkg::RATE_W+4];
            r_loops       <= w_rdata[0];
        end
        if (i_cmd.mul) begin
            r_prod_l <= {7'd0, r_lv} * {14'd0, scvs_pkg::PAN_MAX - r_p};
            r_prod_r <= {7'd0, r_lv} * {14'd0, r_p};
        end
        if (i_cmd.div) begin
            r_lvl_l <= r_center ? r_lv : w_div_l[scvs_pkg::PAN_SHIFT+13:scvs_pkg::PAN_SHIFT];
            r_lvl_r <= r_center ? r_lv : w_div_r[scvs_pkg::PAN_SHIFT+13:scvs_pkg::PAN_SHIFT];
        end
        if (i_cmd.commit) begin
            r_o_status <= r_status;
            r_o_voice  <= w_has_voice ? r_chan : 5'd0;
            r_o_start  <= w_play_ok ? r_start_units : 16'd0;
            r_o_repeat <= w_play_ok ? (r_loops ? r_start_units : scvs_pkg::NOLOOP_UNITS)
                                    : 16'd0;
            r_o_pitch  <= w_play_ok
                          ? {3'd0, r_pitch_prod[42:scvs_pkg::PITCH_SHIFT]}
                          : 16'd0;
            r_o_left   <= w_has_voice ? r_lvl_l : 14'd0;
            r_o_right  <= w_has_voice ? r_lvl_r : 14'd0;
            r_o_count  <= w_new_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_o_status;
    assign o_voice        = r_o_voice;
    assign o_start_units  = r_o_start;
    assign o_repeat_units = r_o_repeat;
    assign o_pitch        = r_o_pitch;
    assign o_left_level   = r_o_left;
    assign o_right_level  = r_o_right;
    assign o_clips_loaded = r_o_count;

endmodule

[sv/sound_clip_table_and_voice_setup_unit.sv]
// Top level of the sound clip table and voice setup unit.
// Each request word on the input channel (i_valid/o_ready) yields exactly one
// result word on the output channel (o_valid/i_ready), in request order.
// A load allocates 16-byte aligned sound RAM for a clip and records it in the
// table; a play reads a loaded clip and returns voice words; a volume request
// returns the voice and its level words; a clear request empties the table.
// After acceptance a request steps through the fetch state, which does the
// pitch and level multiply on the table data read at acceptance, then the pan
// multiply, the reciprocal divide by 127, and the commit to the result register.
// Requests are handled one at a time: a new word is taken only after the last
// has committed, but the next word is taken while a finished result still waits.
// If the receiver stalls, the finished request holds in its commit step and
// the table is updated only when the result enters the output register.
// The user writes ram_base and ram_limit through i_cfg_we only while idle; the
// block does not enforce it. Synchronous reset clears the table, the clip count
// and output valid, rewinds the allocator to the reset ram_base, needs no clearing pass.
module sound_clip_table_and_voice_setup_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [19:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_clip_index,
    input  logic [19:0]       i_size_bytes,
    input  logic [31:0]       i_header_magic,
    input  logic [15:0]       i_sample_rate,
    input  logic              i_loop_flag,
    input  logic signed [8:0] i_volume,
    input  logic signed [8:0] i_pan,
    input  logic [4:0]        i_channel,
    input  logic              i_voice_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [4:0]        o_voice,
    output logic [15:0]       o_start_units,
    output logic [15:0]       o_repeat_units,
    output logic [15:0]       o_pitch,
    output logic [13:0]       o_left_level,
    output logic [13:0]       o_right_level,
    output logic [6:0]        o_clips_loaded
);

    scvs_pkg::t_cmd w_cmd;
    scvs_pkg::t_sts w_sts;

    scvs_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    scvs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_clip_index  (i_clip_index),
        .i_size_bytes  (i_size_bytes),
        .i_header_magic(i_header_magic),
        .i_sample_rate (i_sample_rate),
        .i_loop_flag   (i_loop_flag),
        .i_volume      (i_volume),
        .i_pan         (i_pan),
        .i_channel     (i_channel),
        .i_voice_free  (i_voice_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_voice       (o_voice),
        .o_start_units (o_start_units),
        .o_repeat_units(o_repeat_units),
        .o_pitch       (o_pitch),
        .o_left_level  (o_left_level),
        .o_right_level (o_right_level),
        .o_clips_loaded(o_clips_loaded)
    );

    a_commit_on_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> ##4 (w_cmd.commit || !w_sts.out_free))
        else $error("accepted word did not reach commit in time");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clips_loaded <= 7'(scvs_pkg::CLIP_SLOTS)))
        else $error("clip count exceeds slot count");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != scvs_pkg::ST_OK) |->
        (o_voice == 5'd0 && o_start_units == 16'd0 && o_pitch == 16'd0
         && o_left_level == 14'd0 && o_right_level == 14'd0))
        else $error("failed request carries nonzero result fields");

endmodule
